[rtl/srs_pkg.sv]
// Shared types and constants of the sorted range search block.
`default_nettype none

package srs_pkg;

    localparam int DEPTH  = 1024;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 11;
    localparam int LOHI_W = POS_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [POS_W-1:0] POS_NONE = {POS_W{1'b1}};

    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [LOHI_W-1:0] t_lohi;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_NBR  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[rtl/srs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                                    i_clk,
    input  wire                                    i_wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]                        i_wr_data,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/sorted_range_search.sv]
// Top level of the sorted range search block: entry store and two-pass binary search.
//
// A write item stores one entry; writes to an index at or above DEPTH are
// dropped. A query item runs a leftmost-match search and then, only when that
// one hits, a rightmost-match search over entries 0 to element_count-1 (clamped
// to DEPTH). Each probe uses the single read port of the store, and a probe
// that matches also reads its neighbor unless it is the first or last entry of
// the range. A count of zero skips the search and answers with no match. Items
// are held off by o_stall until a query has delivered its result.
// The store is not cleared by reset; query only entries that were written.
`default_nettype none

module sorted_range_search
    import srs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire [CNT_W-1:0]        i_cfg_wr_data,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_action,
    input  wire [IDX_W-1:0]        i_index,
    input  wire [VALUE_WIDTH-1:0]  i_value,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [POS_W-1:0]       o_first_position,
    output logic [POS_W-1:0]       o_last_position,
    output logic                   o_found
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state                  r_state, n_state;
    t_count                  r_count;
    t_count                  r_n, n_n;
    t_lohi                   r_lo, n_lo, r_hi, n_hi;
    t_pos                    r_mid, n_mid;
    logic                    r_left, n_left;
    logic signed [VALUE_WIDTH-1:0] r_target, n_target;
    t_pos                    r_first, n_first, r_last, n_last;
    logic                    r_hit, n_hit;

    logic                    in_acc;
    logic                    out_free;
    t_count                  n_clamp;
    t_count                  start_n;
    t_lohi                   hi_start;
    t_pos                    mid_start;
    t_lohi                   mid_ext;
    logic                    adv_lo, adv_hi, hit_now;
    t_lohi                   lo_nx, hi_nx, span;
    t_lohi                   mid_sum;
    logic                    cont;
    t_pos                    rd_idx;
    logic [AW+POS_W-1:0]     rd_ext;
    logic [AW+IDX_W-1:0]     wr_ext;
    logic                    wr_en;
    logic [VALUE_WIDTH-1:0]  rd_data;
    logic                    eq, lt, gt;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    assign n_clamp   = (int'(r_count) > DEPTH) ? CNT_W'(DEPTH) : r_count;
    assign start_n   = (r_state == S_IDLE) ? n_clamp : r_n;
    assign hi_start  = t_lohi'({1'b0, start_n}) - t_lohi'(1);
    assign mid_start = POS_W'((start_n - CNT_W'(1)) >> 1);

    assign mid_ext = t_lohi'({1'b0, r_mid});
    assign eq = ($signed(rd_data) == r_target);
    assign lt = ($signed(rd_data) <  r_target);
    assign gt = ($signed(rd_data) >  r_target);

    assign lo_nx   = adv_lo ? (mid_ext + t_lohi'(1)) : r_lo;
    assign hi_nx   = adv_hi ? (mid_ext - t_lohi'(1)) : r_hi;
    assign span    = hi_nx - lo_nx;
    assign mid_sum = lo_nx + (span >>> 1);
    assign cont    = (lo_nx <= hi_nx);

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_left   = r_left;
        n_target = r_target;
        n_first  = r_first;
        n_last   = r_last;
        n_hit    = r_hit;
        rd_idx   = r_mid;
        adv_lo   = 1'b0;
        adv_hi   = 1'b0;
        hit_now  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ACT_QUERY) begin
                    n_target = i_value;
                    n_n      = n_clamp;
                    n_left   = 1'b1;
                    if (n_clamp == '0) begin
                        n_hit   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_lo    = '0;
                        n_hi    = hi_start;
                        n_mid   = mid_start;
                        rd_idx  = mid_start;
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (eq) begin
                    if (r_left) begin
                        if (r_mid == '0) begin
                            hit_now = 1'b1;
                        end else begin
                            rd_idx  = r_mid - POS_W'(1);
                            n_state = S_NBR;
                        end
                    end else begin
                        if (r_mid == POS_W'(r_n - CNT_W'(1))) begin
                            hit_now = 1'b1;
                        end else begin
                            rd_idx  = r_mid + POS_W'(1);
                            n_state = S_NBR;
                        end
                    end
                end else if (lt) begin
                    adv_lo = 1'b1;
                end else begin
                    adv_hi = 1'b1;
                end
            end
            S_NBR: begin
                if (r_left) begin
                    if (lt) begin
                        hit_now = 1'b1;
                    end else begin
                        adv_hi = 1'b1;
                    end
                end else begin
                    if (gt) begin
                        hit_now = 1'b1;
                    end else begin
                        adv_lo = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv_lo || adv_hi) begin
            n_lo = lo_nx;
            n_hi = hi_nx;
            if (cont) begin
                n_mid   = mid_sum[POS_W-1:0];
                rd_idx  = mid_sum[POS_W-1:0];
                n_state = S_CMP;
            end else begin
                n_hit   = 1'b0;
                n_state = S_OUT;
            end
        end

        if (hit_now) begin
            if (r_left) begin
                n_first = r_mid;
                n_left  = 1'b0;
                n_lo    = '0;
                n_hi    = hi_start;
                n_mid   = mid_start;
                rd_idx  = mid_start;
                n_state = S_CMP;
            end else begin
                n_last  = r_mid;
                n_hit   = 1'b1;
                n_state = S_OUT;
            end
        end
    end

    assign rd_ext = {{AW{1'b0}}, rd_idx};
    assign wr_ext = {{AW{1'b0}}, i_index};
    assign wr_en  = in_acc && (i_action == ACT_WRITE) && (int'(i_index) < DEPTH);

    srs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_ext[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (rd_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (r_state == S_OUT && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_left   <= n_left;
        r_target <= n_target;
        r_first  <= n_first;
        r_last   <= n_last;
        r_hit    <= n_hit;
        if (r_state == S_OUT && out_free) begin
            o_first_position <= r_hit ? r_first : POS_NONE;
            o_last_position  <= r_hit ? r_last  : POS_NONE;
            o_found          <= r_hit;
        end
    end

endmodule

`default_nettype wire
